/* sv/tcpg_pkg.sv */
`timescale 1ns / 1ps

package tcpg_pkg;

   localparam int TEX_DEPTH   = 256;
   localparam int SCREEN_ROWS = 1024;
   localparam int ROW_W       = 10;
   localparam int COORD_W     = 32;
   localparam int IPART_W     = 16;
   localparam int TAB_AW      = 8;
   localparam int BYTE_W      = 8;
   localparam int PIX_W       = 16;
   localparam int KIND_W      = 3;
   localparam int MODE_W      = 3;

   typedef enum logic [KIND_W-1:0] {
      REQ_LOAD_TEXEL   = 3'd0,
      REQ_LOAD_LIGHT   = 3'd1,
      REQ_LOAD_PALETTE = 3'd2,
      REQ_LOAD_TRANS   = 3'd3,
      REQ_START        = 3'd4,
      REQ_PIXEL        = 3'd5
   } req_kind_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NORMAL      = 3'd0,
      MODE_SKY         = 3'd1,
      MODE_TRANSLUCENT = 3'd2,
      MODE_TRANSLATED  = 3'd3,
      MODE_SHADE       = 3'd4
   } mode_type;

   typedef struct packed {
      logic              vld;
      logic [KIND_W-1:0] kind;
      logic [TAB_AW-1:0] idx;
      logic [PIX_W-1:0]  val;
      logic [ROW_W-1:0]  row;
      logic              last;
      logic [PIX_W-1:0]  dest;
   } stage_type;

endpackage

/* sv/tcpg_ifs.sv */
`timescale 1ns / 1ps

interface tcpg_req_if import tcpg_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         req_type;
   logic [TAB_AW-1:0]         table_index;
   logic [PIX_W-1:0]          table_value;
   logic [ROW_W-1:0]          first_row;
   logic [ROW_W-1:0]          last_row;
   logic signed [COORD_W-1:0] texture_mid;
   logic signed [COORD_W-1:0] scale_step;
   logic [PIX_W-1:0]          dest_pixel;

   modport source (output valid, req_type, table_index, table_value, first_row, last_row,
                   texture_mid, scale_step, dest_pixel, input ready);
   modport sink (input valid, req_type, table_index, table_value, first_row, last_row,
                 texture_mid, scale_step, dest_pixel, output ready);
endinterface

interface tcpg_rsp_if import tcpg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   logic [ROW_W-1:0] row;
   logic             last;

   modport source (output valid, pixel, row, last, input ready);
   modport sink (input valid, pixel, row, last, output ready);
endinterface

/* sv/tcpg_ram.sv */
`timescale 1ns / 1ps

module tcpg_ram #(
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [1 << ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[waddr] <= wdata;
         end
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tcpg_front.sv */
`timescale 1ns / 1ps

module tcpg_front import tcpg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [MODE_W-1:0] draw_mode,
   input  logic [ROW_W-1:0]  center_row,
   tcpg_req_if.sink          req_chan,
   output stage_type         tex_stage
);

   localparam int RECIP_SH = 24;
   localparam int RECIP    = (1 << RECIP_SH) / TEX_DEPTH;
   localparam int RECIP_W  = $clog2(RECIP + 1);
   localparam int QPROD_W  = IPART_W + RECIP_W;
   localparam int QUOT_W   = $clog2((1 << IPART_W) / TEX_DEPTH + 1);
   localparam int REM_W    = IPART_W + 1;

   logic [COORD_W-1:0] mid_ff, mid_in;
   logic [COORD_W-1:0] acc_ff, acc_in;
   logic [COORD_W-1:0] step_ff, step_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ROW_W-1:0]   end_ff, end_in;
   logic               active_ff, active_in;

   stage_type          s1_ff, s1_in;
   logic [IPART_W-1:0] s1_ipart_ff;
   stage_type          s2_ff;
   logic [IPART_W-1:0] s2_ipart_ff;
   logic [QUOT_W-1:0]  s2_quot_ff, s2_quot_in;

   logic                         accept;
   logic                         fin;
   logic [COORD_W-1:0]           coord;
   logic signed [ROW_W:0]        row_diff;
   logic signed [ROW_W+COORD_W:0] start_prod;
   logic [ROW_W-1:0]             last_clamp;
   logic                         first_ok;
   logic [QPROD_W-1:0]           qprod;
   logic [REM_W-1:0]             rem_raw;
   logic [REM_W-1:0]             rem;
   logic [TAB_AW-1:0]            tex_addr;

   assign req_chan.ready = en;
   assign accept = req_chan.valid && en;
   assign fin    = row_ff >= end_ff;
   assign coord  = mid_ff + acc_ff;

   assign row_diff   = signed'({1'b0, req_chan.first_row}) - signed'({1'b0, center_row});
   assign start_prod = row_diff * req_chan.scale_step;
   assign first_ok   = {1'b0, req_chan.first_row} < (ROW_W+1)'(SCREEN_ROWS);
   assign last_clamp = ({1'b0, req_chan.last_row} > (ROW_W+1)'(SCREEN_ROWS - 1)) ?
                       ROW_W'(SCREEN_ROWS - 1) : req_chan.last_row;

   always_comb begin
      mid_in    = mid_ff;
      acc_in    = acc_ff;
      step_in   = step_ff;
      row_in    = row_ff;
      end_in    = end_ff;
      active_in = active_ff;
      s1_in      = '0;
      s1_in.kind = req_chan.req_type;
      s1_in.idx  = req_chan.table_index;
      s1_in.val  = req_chan.table_value;
      s1_in.row  = row_ff;
      s1_in.last = fin;
      s1_in.dest = req_chan.dest_pixel;
      if (accept) begin
         case (req_chan.req_type)
            REQ_LOAD_TEXEL, REQ_LOAD_LIGHT, REQ_LOAD_PALETTE, REQ_LOAD_TRANS: begin
               s1_in.vld = 1'b1;
            end
            REQ_START: begin
               mid_in    = req_chan.texture_mid;
               acc_in    = start_prod[COORD_W-1:0];
               step_in   = req_chan.scale_step;
               row_in    = req_chan.first_row;
               end_in    = last_clamp;
               active_in = first_ok && (last_clamp >= req_chan.first_row);
            end
            REQ_PIXEL: begin
               if (active_ff) begin
                  s1_in.vld = 1'b1;
                  acc_in    = acc_ff + step_ff;
                  if (fin) begin
                     active_in = 1'b0;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // depth wrap: reciprocal estimate, one correction step
   assign qprod      = QPROD_W'(s1_ipart_ff) * QPROD_W'(RECIP);
   assign s2_quot_in = QUOT_W'(qprod >> RECIP_SH);
   assign rem_raw    = {1'b0, s2_ipart_ff} - REM_W'(s2_quot_ff) * REM_W'(TEX_DEPTH);
   assign rem        = (rem_raw >= REM_W'(TEX_DEPTH)) ? rem_raw - REM_W'(TEX_DEPTH) : rem_raw;

   always_comb begin
      case (draw_mode)
         MODE_SKY: begin
            tex_addr = s2_ipart_ff[TAB_AW-1:0];
         end
         MODE_TRANSLUCENT, MODE_TRANSLATED, MODE_SHADE: begin
            tex_addr = rem[TAB_AW-1:0];
         end
         default: begin
            tex_addr = {1'b0, s2_ipart_ff[TAB_AW-2:0]};
         end
      endcase
      tex_stage = s2_ff;
      if (s2_ff.kind == REQ_PIXEL) begin
         tex_stage.idx = tex_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff    <= '0;
         acc_ff    <= '0;
         step_ff   <= '0;
         row_ff    <= '0;
         end_ff    <= '0;
         active_ff <= 1'b0;
         s1_ff     <= '0;
         s2_ff     <= '0;
      end else if (en) begin
         mid_ff    <= mid_in;
         acc_ff    <= acc_in;
         step_ff   <= step_in;
         row_ff    <= row_in;
         end_ff    <= end_in;
         active_ff <= active_in;
         s1_ff     <= s1_in;
         s2_ff     <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ipart_ff <= coord[COORD_W-1 -: IPART_W];
         s2_ipart_ff <= s1_ipart_ff;
         s2_quot_ff  <= s2_quot_in;
      end
   end

   a_idle_pixel_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.req_type == REQ_PIXEL && !active_ff) |=> !s1_ff.vld)
      else $error("pixel without column entered pipeline");

   a_last_ends_column: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.req_type == REQ_PIXEL && active_ff && fin) |=>
      (!active_ff && s1_ff.vld && s1_ff.last))
      else $error("column still active after last pixel");

endmodule

/* sv/tcpg_shade.sv */
`timescale 1ns / 1ps

module tcpg_shade import tcpg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [MODE_W-1:0] draw_mode,
   input  stage_type         tex_stage,
   tcpg_rsp_if.source        rsp_chan
);

   stage_type         st3_ff, st4_ff, st5_ff, st6_ff;
   logic [BYTE_W-1:0] st4_tex_ff, st5_tex_ff;

   logic [BYTE_W-1:0] texel_rd, trans_rd, light_rd;
   logic [PIX_W-1:0]  pal_rd;
   logic [TAB_AW-1:0] light_raddr, pal_raddr;
   logic [PIX_W-1:0]  color;

   logic             valid_ff, valid_in;
   logic [PIX_W-1:0] pixel_ff;
   logic [ROW_W-1:0] row_ff;
   logic             last_ff;

   function automatic logic [PIX_W-1:0] halve_565(input logic [PIX_W-1:0] p);
      return {1'b0, p[15:12], 1'b0, p[10:6], 1'b0, p[4:1]};
   endfunction

   function automatic logic [PIX_W-1:0] blend_565(input logic [PIX_W-1:0] s,
                                                  input logic [PIX_W-1:0] d);
      logic [5:0] r;
      logic [6:0] g;
      logic [5:0] b;
      r = {1'b0, s[15:11]} + {1'b0, d[15:11]};
      g = {1'b0, s[10:5]} + {1'b0, d[10:5]};
      b = {1'b0, s[4:0]} + {1'b0, d[4:0]};
      return {r[5:1], g[6:1], b[5:1]};
   endfunction

   tcpg_ram #(.WIDTH(BYTE_W), .ADDR_W(TAB_AW)) u_texel (
      .clock (clock),
      .en    (en),
      .we    (tex_stage.vld && tex_stage.kind == REQ_LOAD_TEXEL),
      .waddr (tex_stage.idx),
      .wdata (tex_stage.val[BYTE_W-1:0]),
      .raddr (tex_stage.idx),
      .rdata (texel_rd)
   );

   tcpg_ram #(.WIDTH(BYTE_W), .ADDR_W(TAB_AW)) u_trans (
      .clock (clock),
      .en    (en),
      .we    (st3_ff.vld && st3_ff.kind == REQ_LOAD_TRANS),
      .waddr (st3_ff.idx),
      .wdata (st3_ff.val[BYTE_W-1:0]),
      .raddr (texel_rd),
      .rdata (trans_rd)
   );

   assign light_raddr = (draw_mode == MODE_TRANSLATED) ? trans_rd : st4_tex_ff;

   tcpg_ram #(.WIDTH(BYTE_W), .ADDR_W(TAB_AW)) u_light (
      .clock (clock),
      .en    (en),
      .we    (st4_ff.vld && st4_ff.kind == REQ_LOAD_LIGHT),
      .waddr (st4_ff.idx),
      .wdata (st4_ff.val[BYTE_W-1:0]),
      .raddr (light_raddr),
      .rdata (light_rd)
   );

   // translucent skips the light map
   assign pal_raddr = (draw_mode == MODE_TRANSLUCENT) ? st5_tex_ff : light_rd;

   tcpg_ram #(.WIDTH(PIX_W), .ADDR_W(TAB_AW)) u_palette (
      .clock (clock),
      .en    (en),
      .we    (st5_ff.vld && st5_ff.kind == REQ_LOAD_PALETTE),
      .waddr (st5_ff.idx),
      .wdata (st5_ff.val),
      .raddr (pal_raddr),
      .rdata (pal_rd)
   );

   always_comb begin
      case (draw_mode)
         MODE_TRANSLUCENT: begin
            color = blend_565(pal_rd, st6_ff.dest);
         end
         MODE_SHADE: begin
            color = halve_565(pal_rd);
         end
         default: begin
            color = pal_rd;
         end
      endcase
   end

   assign valid_in = st6_ff.vld && st6_ff.kind == REQ_PIXEL;

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_ff   <= '0;
         st4_ff   <= '0;
         st5_ff   <= '0;
         st6_ff   <= '0;
         valid_ff <= 1'b0;
      end else if (en) begin
         st3_ff   <= tex_stage;
         st4_ff   <= st3_ff;
         st5_ff   <= st4_ff;
         st6_ff   <= st5_ff;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st4_tex_ff <= texel_rd;
         st5_tex_ff <= st4_tex_ff;
         pixel_ff   <= color;
         row_ff     <= st6_ff.row;
         last_ff    <= st6_ff.last;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.pixel = pixel_ff;
   assign rsp_chan.row   = row_ff;
   assign rsp_chan.last  = last_ff;

endmodule

/* sv/textured_column_pixel_generator.sv */
`timescale 1ns / 1ps
// Textured column pixel generator, RGB565 out.
// req_chan (valid/ready) takes words of six kinds: four table loads (texel
// column, light map, palette, translation map), a column start that sets the
// row range and the 16.16 texture coordinate and step, and a pixel request.
// Each pixel request inside an active column returns one word on rsp_chan:
// pixel, row and last (set on the bottom row). Loads, starts and pixels with
// no active column return nothing.
// draw_mode and center_row sit on the APB port; write them only while idle.
// Throughput: one word per cycle in both directions while the receiver
// takes words. A pixel word accepted on req_chan passes the coordinate
// add, the depth wrap, then the texel, translation, light and palette RAM
// reads in turn, then the color stage into the output register, which
// drives rsp_chan.
// When the receiver stalls, the whole pipeline holds and req_chan.ready
// drops until the waiting word is taken.
// Reset clears the column, the pipeline, draw_mode (normal) and center_row
// (100). The tables have no reset; load an entry before it is used.

module textured_column_pixel_generator import tcpg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tcpg_req_if.sink    req_chan,
   tcpg_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic CSR_DRAW_MODE  = 1'b0;
   localparam logic CSR_CENTER_ROW = 1'b1;
   localparam logic [ROW_W-1:0] CENTER_ROW_RESET = ROW_W'(100);

   logic [MODE_W-1:0] draw_mode_ff, draw_mode_in;
   logic [ROW_W-1:0]  center_row_ff, center_row_in;
   logic              csr_wr;
   logic              en;
   stage_type         tex_stage;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign en     = !rsp_chan.valid || rsp_chan.ready;

   always_comb begin
      draw_mode_in  = draw_mode_ff;
      center_row_in = center_row_ff;
      if (csr_wr) begin
         case (paddr[2])
            CSR_DRAW_MODE: begin
               draw_mode_in = pwdata[MODE_W-1:0];
            end
            CSR_CENTER_ROW: begin
               center_row_in = pwdata[ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_DRAW_MODE: begin
            prdata = {{(32 - MODE_W){1'b0}}, draw_mode_ff};
         end
         default: begin
            prdata = {{(32 - ROW_W){1'b0}}, center_row_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_mode_ff  <= MODE_NORMAL;
         center_row_ff <= CENTER_ROW_RESET;
      end else begin
         draw_mode_ff  <= draw_mode_in;
         center_row_ff <= center_row_in;
      end
   end

   tcpg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .draw_mode  (draw_mode_ff),
      .center_row (center_row_ff),
      .req_chan   (req_chan),
      .tex_stage  (tex_stage)
   );

   tcpg_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .draw_mode (draw_mode_ff),
      .tex_stage (tex_stage),
      .rsp_chan  (rsp_chan)
   );

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while output word waits");

   a_center_row_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && paddr[2] == CSR_CENTER_ROW) |=>
      (center_row_ff == $past(pwdata[ROW_W-1:0])))
      else $error("center_row write lost");

endmodule
